[hw/rtl/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants for the soft brush dab blender
// Register indexes, queue payload, blend settings, size limits and pipeline
// step counts.
// ----------------------------------------------------------------------------
package sbd_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RADIUS   = 3'd0,
		REG_HARDNESS = 3'd1,
		REG_OPACITY  = 3'd2,
		REG_COLOR    = 3'd3,
		REG_ERASER   = 3'd4,
		REG_WIDTH    = 3'd5,
		REG_HEIGHT   = 3'd6
	} reg_idx_t;

	// size limits; datapath widths are built for these values
	localparam int MAX_RADIUS    = 256;
	localparam int MAX_IMAGE_DIM = 4096;

	// Q1.16 unity
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// sqrt of d2 << 32: one root bit per step
	localparam int SQ_STEPS   = 25;
	// root / radius: 17 quotient bits
	localparam int DIV1_STEPS = 17;
	// falloff division: 16 quotient bits
	localparam int DIV2_STEPS = 16;

	// pixel coordinate and source color carried down the pipe
	typedef struct packed {
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
	} pix_t;

	// front to back queue entry
	typedef struct packed {
		logic [17:0] d2;
		pix_t        pix;
	} work_t;

	// effective (saturated) blend settings
	typedef struct packed {
		logic [8:0]  radius;
		logic [16:0] h16;
		logic [8:0]  opacity;
		logic [23:0] color;
		logic        eraser;
	} blend_cfg_t;

	// queue handshake status
	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic empty;
	} q_stat_t;

endpackage

[hw/rtl/sbd_if.sv]
// ----------------------------------------------------------------------------
// sbd_if: channel interfaces of the soft brush dab blender
// Input pixel channel, output pixel channel and configuration write channel.
// ----------------------------------------------------------------------------
interface sbd_in_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] center_x;
	logic signed [12:0] center_y;
	logic signed [9:0]  offset_x;
	logic signed [9:0]  offset_y;
	logic [7:0]         src_red;
	logic [7:0]         src_green;
	logic [7:0]         src_blue;
	logic [7:0]         src_alpha;

	modport source(output valid, center_x, center_y, offset_x, offset_y,
		src_red, src_green, src_blue, src_alpha, input ready);
	modport sink(input valid, center_x, center_y, offset_x, offset_y,
		src_red, src_green, src_blue, src_alpha, output ready);
endinterface

interface sbd_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0]  dst_red;
	logic [7:0]  dst_green;
	logic [7:0]  dst_blue;
	logic [7:0]  dst_alpha;

	modport source(output valid, pixel_x, pixel_y, dst_red, dst_green,
		dst_blue, dst_alpha, input ready);
	modport sink(input valid, pixel_x, pixel_y, dst_red, dst_green,
		dst_blue, dst_alpha, output ready);
endinterface

interface sbd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/sbd_front.sv]
// ----------------------------------------------------------------------------
// sbd_front: pixel classifier
// Takes input beats, drops pixels outside the image or the dab disc and
// registers the survivors with their squared distance for the queue.
// ----------------------------------------------------------------------------
module sbd_front (
	input  logic               clk,
	input  logic               arst_n,
	sbd_in_if.sink             in_ch,
	input  logic [8:0]         radius,
	input  logic [12:0]        img_w,
	input  logic [12:0]        img_h,
	input  logic               q_full,
	output logic               work_v_s1,
	output sbd_pkg::work_t     work_s1
);

	logic signed [13:0] x, y;
	logic [9:0]         ax, ay;
	logic [19:0]        sqx, sqy;
	logic [20:0]        d2;
	logic [17:0]        rr;
	logic               in_img, keep;

	// pixel position and squared distance
	always_comb begin
		x      = {in_ch.center_x[12], in_ch.center_x} + {{4{in_ch.offset_x[9]}}, in_ch.offset_x};
		y      = {in_ch.center_y[12], in_ch.center_y} + {{4{in_ch.offset_y[9]}}, in_ch.offset_y};
		ax     = in_ch.offset_x[9] ? (~in_ch.offset_x + 10'd1) : in_ch.offset_x;
		ay     = in_ch.offset_y[9] ? (~in_ch.offset_y + 10'd1) : in_ch.offset_y;
		sqx    = ax * ax;
		sqy    = ay * ay;
		d2     = {1'b0, sqx} + {1'b0, sqy};
		rr     = radius * radius;
		in_img = !x[13] && !y[13] && (x < $signed({1'b0, img_w})) &&
			(y < $signed({1'b0, img_h}));
		keep   = in_img && (d2 <= {3'b0, rr});
	end

	// stage slot frees when empty or when its beat moves into the queue
	assign in_ch.ready = !work_v_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			work_v_s1 <= in_ch.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			work_s1.d2      <= d2[17:0];
			work_s1.pix.px  <= x[11:0];
			work_s1.pix.py  <= y[11:0];
			work_s1.pix.r   <= in_ch.src_red;
			work_s1.pix.g   <= in_ch.src_green;
			work_s1.pix.b   <= in_ch.src_blue;
			work_s1.pix.a   <= in_ch.src_alpha;
		end
	end

endmodule

[hw/rtl/sbd_fifo.sv]
// ----------------------------------------------------------------------------
// sbd_fifo: short queue between classifier and blend pipeline
// Four entries, first-word fall-through read.
// ----------------------------------------------------------------------------
module sbd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sbd_pkg::work_t     push_data,
	input  logic               pop,
	output sbd_pkg::work_t     pop_data,
	output logic               full,
	output logic               empty
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	sbd_pkg::work_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[hw/rtl/sbd_back.sv]
// ----------------------------------------------------------------------------
// sbd_back: falloff and blend pipeline
// Bit-per-stage square root, two bit-per-stage dividers, alpha multiply and
// channel blend. All stages advance together unless the output beat stalls.
// ----------------------------------------------------------------------------
module sbd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbd_pkg::blend_cfg_t  cfg,
	input  sbd_pkg::work_t       q_data,
	input  logic                 q_empty,
	output logic                 q_pop,
	sbd_out_if.source            out_ch
);

	localparam int SQN = sbd_pkg::SQ_STEPS;
	localparam int D1N = sbd_pkg::DIV1_STEPS;
	localparam int D2N = sbd_pkg::DIV2_STEPS;

	logic adv;
	logic out_v_q;

	assign adv   = !out_v_q || out_ch.ready;
	assign q_pop = adv && !q_empty;

	// ---------------- square root of d2 << 32 ----------------
	logic              sq_v_s    [SQN];
	logic [25:0]       sq_rem_s  [SQN];
	logic [24:0]       sq_root_s [SQN];
	sbd_pkg::work_t    sq_w_s    [SQN];

	for (genvar i = 0; i < SQN; i++) begin : g_sq
		logic           v_in;
		logic [25:0]    rem_in;
		logic [24:0]    root_in;
		sbd_pkg::work_t w_in;
		logic [49:0]    n;
		logic [27:0]    cur;
		logic [26:0]    trial;
		logic           ge;

		if (i == 0) begin : g_head
			assign v_in    = !q_empty;
			assign rem_in  = '0;
			assign root_in = '0;
			assign w_in    = q_data;
		end else begin : g_link
			assign v_in    = sq_v_s[i-1];
			assign rem_in  = sq_rem_s[i-1];
			assign root_in = sq_root_s[i-1];
			assign w_in    = sq_w_s[i-1];
		end

		// bring down two radicand bits, try root*4+1
		always_comb begin
			n     = {w_in.d2, 32'b0};
			cur   = {rem_in, n[2*(SQN-1-i) +: 2]};
			trial = {root_in, 2'b01};
			ge    = (cur >= {1'b0, trial});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[i] <= 1'b0;
			else if (adv)
				sq_v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[i]  <= ge ? 26'(cur - {1'b0, trial}) : cur[25:0];
				sq_root_s[i] <= {root_in[23:0], ge};
				sq_w_s[i]    <= w_in;
			end
		end
	end

	// ---------------- norm = root / radius ----------------
	logic              d1_v_s    [D1N];
	logic [8:0]        d1_rem_s  [D1N];
	logic [16:0]       d1_quo_s  [D1N];
	logic [24:0]       d1_root_s [D1N];
	sbd_pkg::pix_t     d1_pix_s  [D1N];

	for (genvar k = 0; k < D1N; k++) begin : g_d1
		logic          v_in;
		logic [8:0]    rem_in;
		logic [16:0]   quo_in;
		logic [24:0]   root_in;
		sbd_pkg::pix_t pix_in;
		logic [9:0]    cur;
		logic          ge;

		if (k == 0) begin : g_head
			assign v_in    = sq_v_s[SQN-1];
			assign rem_in  = {1'b0, sq_root_s[SQN-1][24:17]};
			assign quo_in  = '0;
			assign root_in = sq_root_s[SQN-1];
			assign pix_in  = sq_w_s[SQN-1].pix;
		end else begin : g_link
			assign v_in    = d1_v_s[k-1];
			assign rem_in  = d1_rem_s[k-1];
			assign quo_in  = d1_quo_s[k-1];
			assign root_in = d1_root_s[k-1];
			assign pix_in  = d1_pix_s[k-1];
		end

		always_comb begin
			cur = {rem_in, root_in[D1N-1-k]};
			ge  = (cur >= {1'b0, cfg.radius});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				d1_v_s[k] <= 1'b0;
			else if (adv)
				d1_v_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d1_rem_s[k]  <= ge ? 9'(cur - {1'b0, cfg.radius}) : cur[8:0];
				d1_quo_s[k]  <= {quo_in[15:0], ge};
				d1_root_s[k] <= root_in;
				d1_pix_s[k]  <= pix_in;
			end
		end
	end

	// ---------------- falloff = (1 - norm) / (1 - hardness) ----------------
	logic [16:0] den;
	assign den = 17'({1'b0, sbd_pkg::ONE_Q16} - {1'b0, cfg.h16});

	logic              d2_v_s    [D2N];
	logic              d2_full_s [D2N];
	logic [16:0]       d2_rem_s  [D2N];
	logic [15:0]       d2_quo_s  [D2N];
	sbd_pkg::pix_t     d2_pix_s  [D2N];

	for (genvar j = 0; j < D2N; j++) begin : g_d2
		logic          v_in;
		logic          full_in;
		logic [16:0]   rem_in;
		logic [15:0]   quo_in;
		sbd_pkg::pix_t pix_in;
		logic [17:0]   cur;
		logic          ge;

		if (j == 0) begin : g_head
			assign v_in    = d1_v_s[D1N-1];
			assign full_in = (d1_quo_s[D1N-1] <= cfg.h16);
			assign rem_in  = 17'(sbd_pkg::ONE_Q16 - d1_quo_s[D1N-1]);
			assign quo_in  = '0;
			assign pix_in  = d1_pix_s[D1N-1];
		end else begin : g_link
			assign v_in    = d2_v_s[j-1];
			assign full_in = d2_full_s[j-1];
			assign rem_in  = d2_rem_s[j-1];
			assign quo_in  = d2_quo_s[j-1];
			assign pix_in  = d2_pix_s[j-1];
		end

		always_comb begin
			cur = {rem_in, 1'b0};
			ge  = (cur >= {1'b0, den});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				d2_v_s[j] <= 1'b0;
			else if (adv)
				d2_v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d2_full_s[j] <= full_in;
				d2_rem_s[j]  <= ge ? 17'(cur - {1'b0, den}) : cur[16:0];
				d2_quo_s[j]  <= {quo_in[14:0], ge};
				d2_pix_s[j]  <= pix_in;
			end
		end
	end

	// ---------------- alpha = opacity * falloff ----------------
	logic [16:0]   falloff;
	logic [25:0]   a_prod;
	logic          al_v_s2;
	logic [16:0]   alpha_s2;
	sbd_pkg::pix_t al_pix_s2;

	always_comb begin
		falloff = d2_full_s[D2N-1] ? sbd_pkg::ONE_Q16 : {1'b0, d2_quo_s[D2N-1]};
		a_prod  = cfg.opacity * falloff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			al_v_s2 <= 1'b0;
		else if (adv)
			al_v_s2 <= d2_v_s[D2N-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s2  <= a_prod[24:8];
			al_pix_s2 <= d2_pix_s[D2N-1];
		end
	end

	// ---------------- channel blend, output register ----------------
	function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
		input logic [16:0] al, input logic [16:0] iv);
		logic [24:0] pf, pb, s;
		pf  = fg * al;
		pb  = bg * iv;
		s   = pf + pb;
		mix = s[23:16];
	endfunction

	logic [16:0] inv;
	logic [24:0] erase_prod;
	logic [7:0]  nr, ng, nb, na;

	always_comb begin
		inv        = sbd_pkg::ONE_Q16 - alpha_s2;
		erase_prod = al_pix_s2.a * inv;
		if (cfg.eraser) begin
			nr = al_pix_s2.r;
			ng = al_pix_s2.g;
			nb = al_pix_s2.b;
			na = erase_prod[23:16];
		end else begin
			nr = mix(cfg.color[7:0], al_pix_s2.r, alpha_s2, inv);
			ng = mix(cfg.color[15:8], al_pix_s2.g, alpha_s2, inv);
			nb = mix(cfg.color[23:16], al_pix_s2.b, alpha_s2, inv);
			na = mix(8'd255, al_pix_s2.a, alpha_s2, inv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= al_v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.pixel_x   <= al_pix_s2.px;
			out_ch.pixel_y   <= al_pix_s2.py;
			out_ch.dst_red   <= nr;
			out_ch.dst_green <= ng;
			out_ch.dst_blue  <= nb;
			out_ch.dst_alpha <= na;
		end
	end

	assign out_ch.valid = out_v_q;

endmodule

[hw/rtl/soft_brush_dab_blender.sv]
// ----------------------------------------------------------------------------
// soft_brush_dab_blender: soft round brush dab, one pixel per beat
// Input beat to output beat passes the classifier register, 1 queue write,
// 25 square root steps, 17 + 16 divider steps, 1 alpha and 1 blend stage.
// Throughput: one beat per cycle; the pipeline stalls only on output stall.
// Dropped pixels leave no output beat. Asynchronous active-low reset clears
// pipeline valids and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module soft_brush_dab_blender (
	input  logic       clk,
	input  logic       arst_n,
	sbd_cfg_if.sink    cfg,
	sbd_in_if.sink     in_ch,
	sbd_out_if.source  out_ch
);

	logic [8:0]  radius_q, hardness_q, opacity_q;
	logic [23:0] color_q;
	logic        eraser_q;
	logic [12:0] width_q, height_q;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 9'd16;
			hardness_q <= 9'd77;
			opacity_q  <= 9'd192;
			color_q    <= '0;
			eraser_q   <= 1'b0;
			width_q    <= 13'd1024;
			height_q   <= 13'd1024;
		end else if (cfg.valid) begin
			case (sbd_pkg::reg_idx_t'(cfg.index))
				sbd_pkg::REG_RADIUS:   radius_q   <= cfg.data[8:0];
				sbd_pkg::REG_HARDNESS: hardness_q <= cfg.data[8:0];
				sbd_pkg::REG_OPACITY:  opacity_q  <= cfg.data[8:0];
				sbd_pkg::REG_COLOR:    color_q    <= cfg.data;
				sbd_pkg::REG_ERASER:   eraser_q   <= cfg.data[0];
				sbd_pkg::REG_WIDTH:    width_q    <= cfg.data[12:0];
				sbd_pkg::REG_HEIGHT:   height_q   <= cfg.data[12:0];
				default: ;
			endcase
		end
	end

	// saturated settings
	sbd_pkg::blend_cfg_t bcfg;
	logic [8:0]          r_sat;
	logic [12:0]         w_eff, h_eff;

	always_comb begin
		r_sat        = (int'(radius_q) > sbd_pkg::MAX_RADIUS) ?
			9'(sbd_pkg::MAX_RADIUS) : radius_q;
		bcfg.radius  = (r_sat == '0) ? 9'd1 : r_sat;
		bcfg.h16     = (hardness_q > 9'd256) ? sbd_pkg::ONE_Q16 : {hardness_q[7:0] == 8'd0 &&
			hardness_q[8], hardness_q[7:0], 8'b0};
		bcfg.opacity = (opacity_q > 9'd256) ? 9'd256 : opacity_q;
		bcfg.color   = color_q;
		bcfg.eraser  = eraser_q;
		w_eff        = (int'(width_q) > sbd_pkg::MAX_IMAGE_DIM) ?
			13'(sbd_pkg::MAX_IMAGE_DIM) : width_q;
		h_eff        = (int'(height_q) > sbd_pkg::MAX_IMAGE_DIM) ?
			13'(sbd_pkg::MAX_IMAGE_DIM) : height_q;
	end

	// front: classify
	logic            work_v_s1;
	sbd_pkg::work_t  work_s1;
	sbd_pkg::work_t  q_data;
	sbd_pkg::q_stat_t qs;

	sbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.radius    (bcfg.radius),
		.img_w     (w_eff),
		.img_h     (h_eff),
		.q_full    (qs.full),
		.work_v_s1 (work_v_s1),
		.work_s1   (work_s1)
	);

	assign qs.push = work_v_s1;

	// queue
	sbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (qs.push),
		.push_data (work_s1),
		.pop       (qs.pop),
		.pop_data  (q_data),
		.full      (qs.full),
		.empty     (qs.empty)
	);

	// back: falloff and blend
	sbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (bcfg),
		.q_data  (q_data),
		.q_empty (qs.empty),
		.q_pop   (qs.pop),
		.out_ch  (out_ch)
	);

`ifndef SYNTH
	// front holds its beat while the queue is full, so a held beat leaves only on a push
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(qs.push && qs.full) |=> work_v_s1)
		else $error("front dropped a beat while the queue was full");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qs.pop && qs.empty))
		else $error("queue popped while empty");

	// a full queue with no pop stays full
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(qs.full && !qs.pop) |=> qs.full)
		else $error("queue lost an entry");
`endif

endmodule

[tb/sbd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_checker: blend predictor and scoreboard for the soft brush dab blender
// Watches the configuration, input and output channels, computes the new
// pixel for every accepted input beat and compares each output beat against
// the oldest pending pixel.
// ----------------------------------------------------------------------------
module sbd_checker (
	input  logic      clk,
	input  logic      arst_n,
	sbd_cfg_if.sink   cfg,
	sbd_in_if.sink    in_ch,
	sbd_out_if.sink   out_ch,
	output int        err_count,
	output int        pending
);

	typedef struct packed {
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
	} dab_pix_t;

	logic [8:0]  radius_q;
	logic [8:0]  hardness_q;
	logic [8:0]  opacity_q;
	logic [23:0] color_q;
	logic        eraser_q;
	logic [12:0] width_q;
	logic [12:0] height_q;

	dab_pix_t pix_q[$];

	assign pending = pix_q.size();

	// integer square root, one result bit per step
	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// new pixel for one input beat; returns 0 when the pixel is dropped
	function automatic bit blend_pixel(
		input logic signed [12:0] cx, input logic signed [12:0] cy,
		input logic signed [9:0] ox, input logic signed [9:0] oy,
		input logic [7:0] sr, input logic [7:0] sg,
		input logic [7:0] sb, input logic [7:0] sa,
		output dab_pix_t res);
		longint unsigned rad, h16, op, ax, ay, d2, nrm, fall, alpha, inv;
		longint unsigned dr, dg, db, da;
		longint w, hgt, x, y;
		rad = (radius_q > 256) ? 256 : radius_q;
		if (rad == 0)
			rad = 1;
		h16 = ((hardness_q > 256) ? 256 : hardness_q) << 8;
		op = (opacity_q > 256) ? 256 : opacity_q;
		w = (width_q > 4096) ? 4096 : width_q;
		hgt = (height_q > 4096) ? 4096 : height_q;
		x = longint'(cx) + longint'(ox);
		y = longint'(cy) + longint'(oy);
		res = '0;
		if (x < 0 || y < 0 || x >= w || y >= hgt)
			return 0;
		ax = (ox < 0) ? -longint'(ox) : longint'(ox);
		ay = (oy < 0) ? -longint'(oy) : longint'(oy);
		d2 = ax * ax + ay * ay;
		if (d2 > rad * rad)
			return 0;
		nrm = root64(d2 << 32) / rad;
		if (nrm > 65536)
			nrm = 65536;
		fall = 65536;
		if (nrm > h16)
			fall = ((65536 - nrm) << 16) / (65536 - h16);
		alpha = (op * fall) >> 8;
		inv = 65536 - alpha;
		dr = sr;
		dg = sg;
		db = sb;
		if (eraser_q) begin
			da = (sa * inv) >> 16;
		end else begin
			dr = (color_q[7:0] * alpha + sr * inv) >> 16;
			dg = (color_q[15:8] * alpha + sg * inv) >> 16;
			db = (color_q[23:16] * alpha + sb * inv) >> 16;
			da = (255 * alpha + sa * inv) >> 16;
		end
		res.px = x[11:0];
		res.py = y[11:0];
		res.r = dr[7:0];
		res.g = dg[7:0];
		res.b = db[7:0];
		res.a = da[7:0];
		return 1;
	endfunction

	// shadow registers, predictions and comparison
	always @(posedge clk or negedge arst_n) begin
		dab_pix_t pred;
		dab_pix_t got;
		dab_pix_t want;
		if (!arst_n) begin
			radius_q   <= 9'd16;
			hardness_q <= 9'd77;
			opacity_q  <= 9'd192;
			color_q    <= '0;
			eraser_q   <= 1'b0;
			width_q    <= 13'd1024;
			height_q   <= 13'd1024;
			err_count  <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (sbd_pkg::reg_idx_t'(cfg.index))
					sbd_pkg::REG_RADIUS:   radius_q   <= cfg.data[8:0];
					sbd_pkg::REG_HARDNESS: hardness_q <= cfg.data[8:0];
					sbd_pkg::REG_OPACITY:  opacity_q  <= cfg.data[8:0];
					sbd_pkg::REG_COLOR:    color_q    <= cfg.data;
					sbd_pkg::REG_ERASER:   eraser_q   <= cfg.data[0];
					sbd_pkg::REG_WIDTH:    width_q    <= cfg.data[12:0];
					sbd_pkg::REG_HEIGHT:   height_q   <= cfg.data[12:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				if (blend_pixel(in_ch.center_x, in_ch.center_y, in_ch.offset_x,
						in_ch.offset_y, in_ch.src_red, in_ch.src_green,
						in_ch.src_blue, in_ch.src_alpha, pred))
					pix_q.push_back(pred);
			end
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.pixel_x, out_ch.pixel_y, out_ch.dst_red,
					out_ch.dst_green, out_ch.dst_blue, out_ch.dst_alpha};
				if (pix_q.size() == 0) begin
					if (err_count < 10)
						$display("unexpected output beat: %p", got);
					err_count <= err_count + 1;
				end else begin
					want = pix_q.pop_front();
					if (got != want) begin
						if (err_count < 10)
							$display("pixel mismatch: expected %p, got %p",
								want, got);
						err_count <= err_count + 1;
					end
				end
			end
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the soft brush dab blender
// Drives configuration phases, directed and random dab pixels with bursty
// input and a stalling output, then reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY = 61;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	int   err_count;
	int   pending;
	int   idle_cycles;
	bit   timed_out;

	sbd_cfg_if cfg();
	sbd_in_if  in_ch();
	sbd_out_if out_ch();

	soft_brush_dab_blender dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

	sbd_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
		.err_count(err_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// output stall pattern: phases of no stall, light and heavy stall
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input sbd_pkg::reg_idx_t idx, input logic [23:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10)
			@(negedge clk);
	endtask

	// one input beat; valid stays high between back to back beats
	task automatic send_pixel(input logic signed [12:0] cx, input logic signed [12:0] cy,
		input logic signed [9:0] ox, input logic signed [9:0] oy, input logic [31:0] rgba);
		in_ch.valid     <= 1'b1;
		in_ch.center_x  <= cx;
		in_ch.center_y  <= cy;
		in_ch.offset_x  <= ox;
		in_ch.offset_y  <= oy;
		in_ch.src_red   <= rgba[7:0];
		in_ch.src_green <= rgba[15:8];
		in_ch.src_blue  <= rgba[23:16];
		in_ch.src_alpha <= rgba[31:24];
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_ch.valid <= 1'b0;
		repeat (n)
			@(negedge clk);
	endtask

	// random beat: mostly inside the dab and image, some noise
	task automatic random_pixel(input int rad, input int w, input int h);
		logic signed [12:0] cx, cy;
		logic signed [9:0] ox, oy;
		int lim;
		lim = (rad > 256) ? 256 : ((rad < 1) ? 1 : rad);
		if ($urandom_range(0, 4) == 0) begin
			cx = 13'($urandom);
			cy = 13'($urandom);
			ox = 10'(int'($urandom_range(0, 512)) - 256);
			oy = 10'(int'($urandom_range(0, 512)) - 256);
		end else begin
			ox = 10'(int'($urandom_range(0, 2 * lim)) - lim);
			oy = 10'(int'($urandom_range(0, 2 * lim)) - lim);
			cx = 13'(int'($urandom_range(0, (w > 4096 ? 4096 : w) - 1)) - int'(ox));
			cy = 13'(int'($urandom_range(0, (h > 4096 ? 4096 : h) - 1)) - int'(oy));
		end
		send_pixel(cx, cy, ox, oy, $urandom);
	endtask

	initial begin
		int n;
		int rad, w, h;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = sbd_pkg::REG_RADIUS;
		cfg.data = '0;
		in_ch.valid = 1'b0;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		in_ch.offset_x = '0;
		in_ch.offset_y = '0;
		in_ch.src_red = '0;
		in_ch.src_green = '0;
		in_ch.src_blue = '0;
		in_ch.src_alpha = '0;
		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, extremes of the fields
		send_pixel(13'sd100, 13'sd100, 10'sd0, 10'sd0, 32'hFF00FF00);
		send_pixel(13'sd100, 13'sd100, 10'sd16, 10'sd0, 32'h00FFFFFF);
		send_pixel(13'sd100, 13'sd100, 10'sd12, 10'sd12, 32'h80402010);
		send_pixel(13'sd100, 13'sd100, 10'sd17, 10'sd0, 32'h11111111);
		send_pixel(-13'sd4096, 13'sd5, 10'sd0, 10'sd0, 32'h0);
		send_pixel(13'sd4095, 13'sd5, 10'sd0, 10'sd0, 32'h0);
		send_pixel(13'sd1023, 13'sd1023, 10'sd0, 10'sd0, 32'hFFFFFFFF);
		send_pixel(13'sd1024, 13'sd10, 10'sd0, 10'sd0, 32'h0);
		send_pixel(13'sd5, -13'sd1, 10'sd0, 10'sd0, 32'h0);
		send_pixel(13'sd300, 13'sd300, -10'sd256, 10'sd256, 32'h0);
		idle_gap(1);
		drain();

		// directed: saturation extremes, full hardness, full opacity
		write_reg(sbd_pkg::REG_RADIUS, 24'h1FF);
		write_reg(sbd_pkg::REG_HARDNESS, 24'h1FF);
		write_reg(sbd_pkg::REG_OPACITY, 24'h1FF);
		write_reg(sbd_pkg::REG_COLOR, 24'hFFFFFF);
		write_reg(sbd_pkg::REG_WIDTH, 24'h1FFF);
		write_reg(sbd_pkg::REG_HEIGHT, 24'h1FFF);
		send_pixel(13'sd4095, 13'sd4095, 10'sd0, 10'sd0, 32'h00000000);
		send_pixel(13'sd3000, 13'sd3000, 10'sd256, 10'sd0, 32'h12345678);
		send_pixel(13'sd3000, 13'sd3000, -10'sd256, -10'sd256, 32'h0);
		send_pixel(13'sd3000, 13'sd3000, -10'sd181, 10'sd181, 32'hA5A5A5A5);
		send_pixel(13'sd0, 13'sd0, 10'sd0, 10'sd0, 32'h5A5A5A5A);
		idle_gap(1);
		drain();

		// directed: radius zero, zero hardness and opacity, eraser, empty image
		write_reg(sbd_pkg::REG_RADIUS, 24'd0);
		write_reg(sbd_pkg::REG_HARDNESS, 24'd0);
		write_reg(sbd_pkg::REG_OPACITY, 24'd0);
		write_reg(sbd_pkg::REG_ERASER, 24'd1);
		write_reg(sbd_pkg::REG_WIDTH, 24'd1);
		write_reg(sbd_pkg::REG_HEIGHT, 24'd1);
		send_pixel(13'sd0, 13'sd0, 10'sd0, 10'sd0, 32'hFFFFFFFF);
		send_pixel(13'sd1, 13'sd0, -10'sd1, 10'sd0, 32'hFF000000);
		idle_gap(1);
		drain();
		write_reg(sbd_pkg::REG_OPACITY, 24'd256);
		send_pixel(13'sd0, 13'sd0, 10'sd0, 10'sd0, 32'hFF123456);
		send_pixel(13'sd0, 13'sd1, 10'sd0, -10'sd1, 32'h80FFFFFF);
		idle_gap(1);
		drain();
		write_reg(sbd_pkg::REG_WIDTH, 24'd0);
		send_pixel(13'sd0, 13'sd0, 10'sd0, 10'sd0, 32'hFF000000);
		idle_gap(1);
		drain();

		// random phases over several settings
		for (int phase = 0; phase < 6; phase++) begin
			rad = (phase == 0) ? 1 : ((phase == 5) ? 256 : $urandom_range(1, 40));
			w = (phase == 3) ? 4096 : $urandom_range(64, 2048);
			h = (phase == 4) ? 4096 : $urandom_range(64, 2048);
			write_reg(sbd_pkg::REG_RADIUS, 24'(rad));
			write_reg(sbd_pkg::REG_HARDNESS,
				24'((phase == 1) ? 256 : $urandom_range(0, 300)));
			write_reg(sbd_pkg::REG_OPACITY,
				24'((phase == 2) ? 0 : $urandom_range(0, 300)));
			write_reg(sbd_pkg::REG_COLOR, 24'($urandom));
			write_reg(sbd_pkg::REG_ERASER, 24'(phase % 2));
			write_reg(sbd_pkg::REG_WIDTH, 24'(w));
			write_reg(sbd_pkg::REG_HEIGHT, 24'(h));
			n = 0;
			while (n < 64) begin
				repeat ($urandom_range(1, 20)) begin
					random_pixel(rad, w, h);
					n++;
				end
				if ($urandom_range(0, 2) != 0)
					idle_gap($urandom_range(1, 8));
			end
			idle_gap(1);
			drain();
		end

		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sbd_pkg.sv
hw/rtl/sbd_if.sv
hw/rtl/sbd_front.sv
hw/rtl/sbd_fifo.sv
hw/rtl/sbd_back.sv
hw/rtl/soft_brush_dab_blender.sv
tb/sbd_checker.sv
tb/testbench.sv
